>>> design/tsfa_pkg.sv
// Package for the touch sample filter and averager.
// Holds widths, event and panel mode codes, and the per-axis filter result type.
// No dependencies; used by tsfa_axis_filter and touch_sample_filter_averager.
package tsfa_pkg;

    // Width of a stored conversion sample.
    localparam int SAMPLE_W   = 10;
    // Width of the conversion fields on the input port.
    localparam int CONV_W     = 10;
    // Width of the reported position fields.
    localparam int POS_W      = 10;
    // Width of the deviation limit register.
    localparam int LIMIT_W    = 10;
    // Width used when comparing a deviation against the limit.
    localparam int CMP_W      = (SAMPLE_W > LIMIT_W) ? SAMPLE_W : LIMIT_W;
    // Width of a sum of four samples.
    localparam int SUM4_W     = SAMPLE_W + 2;
    // Number of samples gathered before the filter runs.
    localparam int NUM_SAMPLES = 4;
    localparam int COUNT_W    = $clog2(NUM_SAMPLES);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    // Event kinds.
    localparam logic [1:0] KIND_PEN_IRQ  = 2'd0;
    localparam logic [1:0] KIND_CONV     = 2'd1;
    localparam logic [1:0] KIND_TIMER    = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // Panel modes.
    localparam logic [1:0] MODE_WAIT_DOWN = 2'd0;
    localparam logic [1:0] MODE_WAIT_UP   = 2'd1;
    localparam logic [1:0] MODE_MEASURE   = 2'd2;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Outcome of the filter on one axis.
    typedef struct packed {
        logic             pass;
        logic [POS_W-1:0] average;
    } t_axis_result;

endpackage

>>> design/tsfa_axis_filter.sv
// Deviation check and four-sample floor average for one axis.
// Depends on tsfa_pkg.
module tsfa_axis_filter (
    input  tsfa_pkg::t_sample                 i_s0,
    input  tsfa_pkg::t_sample                 i_s1,
    input  tsfa_pkg::t_sample                 i_s2,
    input  tsfa_pkg::t_sample                 i_s3,
    input  logic [tsfa_pkg::LIMIT_W-1:0]      i_limit,
    output tsfa_pkg::t_axis_result            o_result
);

    logic [tsfa_pkg::SAMPLE_W:0]   sum01;
    logic [tsfa_pkg::SAMPLE_W:0]   sum12;
    tsfa_pkg::t_sample             mean01;
    tsfa_pkg::t_sample             mean12;
    tsfa_pkg::t_sample             dev2;
    tsfa_pkg::t_sample             dev3;
    logic [tsfa_pkg::CMP_W-1:0]    limit_ext;
    logic [tsfa_pkg::SUM4_W-1:0]   sum4;

    // Means of neighboring pairs fit back into a sample after the shift.
    assign sum01  = {1'b0, i_s0} + {1'b0, i_s1};
    assign sum12  = {1'b0, i_s1} + {1'b0, i_s2};
    assign mean01 = sum01[tsfa_pkg::SAMPLE_W:1];
    assign mean12 = sum12[tsfa_pkg::SAMPLE_W:1];

    assign dev2 = (i_s2 >= mean01) ? (i_s2 - mean01) : (mean01 - i_s2);
    assign dev3 = (i_s3 >= mean12) ? (i_s3 - mean12) : (mean12 - i_s3);

    assign limit_ext = tsfa_pkg::CMP_W'(i_limit);

    assign sum4 = tsfa_pkg::SUM4_W'(i_s0) + tsfa_pkg::SUM4_W'(i_s1)
                + tsfa_pkg::SUM4_W'(i_s2) + tsfa_pkg::SUM4_W'(i_s3);

    always_comb begin
        o_result.pass    = (tsfa_pkg::CMP_W'(dev2) <= limit_ext)
                        && (tsfa_pkg::CMP_W'(dev3) <= limit_ext);
        o_result.average = tsfa_pkg::POS_W'(sum4 >> 2);
    end

endmodule

>>> design/touch_sample_filter_averager.sv
// Top level of the touch sample filter and averager.
// Depends on tsfa_pkg and tsfa_axis_filter.
//
// This block sits behind a resistive touch panel controller and turns its
// events into touch reports. Each input item is one event (pen interrupt,
// conversion done or re-sample timer expiry) with the pen-up flag and an
// x/y conversion. A pen-up event yields a release report and the wait for
// pen down; a pen-down conversion is stored until four have been gathered,
// and on the fourth the block checks samples 2 and 3 against the floor mean
// of the two samples before each, reports the floor average of all four if
// both stay within the deviation limit, and asks for the wait for pen up and
// the re-sample timer. Every event except the unused kind three yields exactly
// one result item; kind three is dropped without effect. The block takes one
// item per clock cycle while the input side does not stall. An item is held in
// the input register, then the filter and averaging logic load its result into
// the result register, from which the result is presented. The input side
// stalls only when both registers hold items that the output side has not
// taken. The deviation limit resets to 10 and is written through the cfg
// channel, which is always ready; the user must write it only while no item
// is in flight, as the block itself does not enforce this.
module touch_sample_filter_averager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: deviation_limit in the low bits.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // [9:0] deviation_limit
    // Event items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [0] pen_up, [10:1] x_sample, [20:11] y_sample
    input  logic [1:0]  s_axis_tuser,    // [1:0] kind
    // Report items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [0] report_release, [1] report_position,
                                         // [11:2] x_position, [21:12] y_position,
                                         // [23:22] panel_mode, [24] arm_timer
);

    localparam int CW = tsfa_pkg::CONV_W;
    localparam int PW = tsfa_pkg::POS_W;

    // Input register.
    logic                 r_in_valid;
    logic [1:0]           r_in_kind;
    logic                 r_in_pen_up;
    logic [CW-1:0]        r_in_x;
    logic [CW-1:0]        r_in_y;

    // Block state.
    logic [tsfa_pkg::LIMIT_W-1:0]  r_limit;
    logic [tsfa_pkg::COUNT_W-1:0]  r_count;
    logic [tsfa_pkg::COUNT_W-1:0]  n_count;
    // Only the first three samples of a run are kept; the fourth is the live item.
    tsfa_pkg::t_sample             r_x_mem [tsfa_pkg::NUM_SAMPLES-1];
    tsfa_pkg::t_sample             r_y_mem [tsfa_pkg::NUM_SAMPLES-1];

    // Result register.
    logic                 r_out_valid;
    logic                 r_out_release;
    logic                 r_out_position;
    logic [PW-1:0]        r_out_x;
    logic [PW-1:0]        r_out_y;
    logic [1:0]           r_out_mode;
    logic                 r_out_arm;

    logic                 n_release;
    logic                 n_position;
    logic [PW-1:0]        n_x;
    logic [PW-1:0]        n_y;
    logic [1:0]           n_mode;
    logic                 n_arm;
    logic                 store_sample;

    logic                 advance;
    logic                 in_accept;
    tsfa_pkg::t_sample    x_live;
    tsfa_pkg::t_sample    y_live;
    tsfa_pkg::t_axis_result x_res;
    tsfa_pkg::t_axis_result y_res;

    // The item in the input register moves on when the result register is free
    // or is being emptied in the same cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign x_live = tsfa_pkg::SAMPLE_W'(r_in_x);
    assign y_live = tsfa_pkg::SAMPLE_W'(r_in_y);

    tsfa_axis_filter u_x_filter (
        .i_s0     (r_x_mem[0]),
        .i_s1     (r_x_mem[1]),
        .i_s2     (r_x_mem[2]),
        .i_s3     (x_live),
        .i_limit  (r_limit),
        .o_result (x_res)
    );

    tsfa_axis_filter u_y_filter (
        .i_s0     (r_y_mem[0]),
        .i_s1     (r_y_mem[1]),
        .i_s2     (r_y_mem[2]),
        .i_s3     (y_live),
        .i_limit  (r_limit),
        .o_result (y_res)
    );

    // Event decode for the item in the input register.
    always_comb begin
        n_count      = r_count;
        n_release    = 1'b0;
        n_position   = 1'b0;
        n_x          = '0;
        n_y          = '0;
        n_mode       = tsfa_pkg::MODE_WAIT_DOWN;
        n_arm        = 1'b0;
        store_sample = 1'b0;
        if (r_in_pen_up) begin
            // A conversion with the pen lifted abandons the current run.
            if (r_in_kind == tsfa_pkg::KIND_CONV) begin
                n_count = '0;
            end
            n_release = 1'b1;
            n_mode    = tsfa_pkg::MODE_WAIT_DOWN;
        end else if (r_in_kind != tsfa_pkg::KIND_CONV) begin
            n_mode = tsfa_pkg::MODE_MEASURE;
        end else if (r_count == tsfa_pkg::COUNT_W'(tsfa_pkg::NUM_SAMPLES - 1)) begin
            // Fourth sample of the run: filter and report.
            n_position = x_res.pass && y_res.pass;
            if (n_position) begin
                n_x = x_res.average;
                n_y = y_res.average;
            end
            n_count = '0;
            n_mode  = tsfa_pkg::MODE_WAIT_UP;
            n_arm   = 1'b1;
        end else begin
            store_sample = 1'b1;
            n_count      = r_count + 1'b1;
            n_mode       = tsfa_pkg::MODE_MEASURE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_limit     <= tsfa_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data[tsfa_pkg::LIMIT_W-1:0];
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && (r_in_kind != tsfa_pkg::KIND_UNUSED)) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers and sample store.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind   <= s_axis_tuser;
            r_in_pen_up <= s_axis_tdata[0];
            r_in_x      <= s_axis_tdata[CW:1];
            r_in_y      <= s_axis_tdata[2*CW:CW+1];
        end
        if (advance && (r_in_kind != tsfa_pkg::KIND_UNUSED)) begin
            r_out_release  <= n_release;
            r_out_position <= n_position;
            r_out_x        <= n_x;
            r_out_y        <= n_y;
            r_out_mode     <= n_mode;
            r_out_arm      <= n_arm;
            if (store_sample) begin
                r_x_mem[r_count] <= x_live;
                r_y_mem[r_count] <= y_live;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_arm, r_out_mode, r_out_y, r_out_x,
                            r_out_position, r_out_release};

endmodule
